// ===== design/jcs_pkg.sv =====
// ---------------------------------------------------------------------------
// Joint command smoother package
// Shared types, operation codes and register map for the smoother.
// ---------------------------------------------------------------------------
package jcs_pkg;

  localparam int unsigned JOINTS    = 7;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned WEIGHT_W  = 17;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned OVF_W     = 16;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned WSHIFT    = 16;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = WEIGHT_W'(65536);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET   = WEIGHT_W'(32768);
  localparam logic [COUNT_W-1:0]  LIMIT_RESET    = COUNT_W'(10);
  localparam logic [OVF_W-1:0]    OVF_MAX        = {OVF_W{1'b1}};

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_SMOOTHING_ON = 2'd0,
    REG_BLEND_WEIGHT = 2'd1,
    REG_BUFFER_LIMIT = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_INIT  = 2'd3
  } op_t;

  typedef logic signed [POS_W-1:0] pos_t;

  // Per-word commands broadcast from the control block to every lane.
  typedef struct packed {
    logic load_target;
    logic load_last;
    logic copy_target;
    logic blend;
  } lane_ctl_t;

  typedef struct packed {
    logic                          out_valid;
    logic [JOINTS-1:0][POS_W-1:0]  joints;
    logic [COUNT_W-1:0]            occupancy;
    logic [OVF_W-1:0]              overflow_total;
  } res_t;

endpackage

// ===== design/jcs_cmd_if.sv =====
// ---------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one operation and seven joint positions.
// ---------------------------------------------------------------------------
interface jcs_cmd_if;
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic signed [31:0]  joint_a;
  logic signed [31:0]  joint_b;
  logic signed [31:0]  joint_c;
  logic signed [31:0]  joint_d;
  logic signed [31:0]  joint_e;
  logic signed [31:0]  joint_f;
  logic signed [31:0]  joint_g;

  modport source (output valid, operation, joint_a, joint_b, joint_c, joint_d,
                  joint_e, joint_f, joint_g, input ready);
  modport sink (input valid, operation, joint_a, joint_b, joint_c, joint_d,
                joint_e, joint_f, joint_g, output ready);
endinterface

// ===== design/jcs_res_if.sv =====
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the smoothed positions and the counters.
// ---------------------------------------------------------------------------
interface jcs_res_if;
  logic                valid;
  logic                ready;
  logic                out_valid;
  logic signed [31:0]  out_joint_a;
  logic signed [31:0]  out_joint_b;
  logic signed [31:0]  out_joint_c;
  logic signed [31:0]  out_joint_d;
  logic signed [31:0]  out_joint_e;
  logic signed [31:0]  out_joint_f;
  logic signed [31:0]  out_joint_g;
  logic [10:0]         occupancy;
  logic [15:0]         overflow_total;

  modport source (output valid, out_valid, out_joint_a, out_joint_b, out_joint_c,
                  out_joint_d, out_joint_e, out_joint_f, out_joint_g, occupancy,
                  overflow_total, input ready);
  modport sink (input valid, out_valid, out_joint_a, out_joint_b, out_joint_c,
                out_joint_d, out_joint_e, out_joint_f, out_joint_g, occupancy,
                overflow_total, output ready);
endinterface

// ===== design/jcs_lane.sv =====
// ---------------------------------------------------------------------------
// Joint lane
// Holds one joint's target and last output and computes the blended step.
// ---------------------------------------------------------------------------
module jcs_lane (
  input  logic                               clk,
  input  jcs_pkg::lane_ctl_t                 ctl,
  input  logic [jcs_pkg::WEIGHT_W-1:0]       weight,
  input  jcs_pkg::pos_t                      pos_in,
  output jcs_pkg::pos_t                      pos_out
);

  localparam int unsigned DIFF_W = jcs_pkg::POS_W + 1;
  localparam int unsigned PROD_W = DIFF_W + jcs_pkg::WEIGHT_W + 1;

  jcs_pkg::pos_t              target;
  jcs_pkg::pos_t              last;
  jcs_pkg::pos_t              last_next;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod;

  // The blended value always lies between last and target, so the sum may be
  // taken modulo 2^32 without losing anything.
  always_comb begin
    diff = DIFF_W'(target) - DIFF_W'(last);
    prod = PROD_W'(diff) * $signed({1'b0, weight});
    if (ctl.load_last) begin
      last_next = pos_in;
    end else if (ctl.copy_target) begin
      last_next = target;
    end else if (ctl.blend) begin
      last_next = last + prod[jcs_pkg::WSHIFT +: jcs_pkg::POS_W];
    end else begin
      last_next = last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_target) begin
      target <= pos_in;
    end
    last <= last_next;
  end

  assign pos_out = last_next;

endmodule

// ===== design/jcs_ctrl.sv =====
// ---------------------------------------------------------------------------
// Smoother control
// Decodes each word, keeps occupancy, overflow and last-output status.
// ---------------------------------------------------------------------------
module jcs_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [1:0]                      operation,
  input  logic                            smoothing_on,
  input  logic [jcs_pkg::COUNT_W-1:0]     buffer_limit,
  output jcs_pkg::lane_ctl_t              ctl,
  output logic                            tick_valid,
  output logic [jcs_pkg::COUNT_W-1:0]     occupancy,
  output logic [jcs_pkg::OVF_W-1:0]       overflow_total
);

  logic [jcs_pkg::COUNT_W-1:0] held_count;
  logic [jcs_pkg::COUNT_W-1:0] held_count_next;
  logic [jcs_pkg::OVF_W-1:0]   overflow_count;
  logic [jcs_pkg::OVF_W-1:0]   overflow_count_next;
  logic                        last_valid;
  logic                        last_valid_next;
  logic [jcs_pkg::COUNT_W-1:0] limit;
  jcs_pkg::op_t                op;

  always_comb begin
    op                  = jcs_pkg::op_t'(operation);
    limit               = (buffer_limit == '0) ? jcs_pkg::COUNT_W'(1) : buffer_limit;
    held_count_next     = held_count;
    overflow_count_next = overflow_count;
    last_valid_next     = last_valid;
    ctl                 = '0;
    tick_valid          = 1'b0;
    if (accept) begin
      unique case (op)
        jcs_pkg::OP_ADD: begin
          ctl.load_target = 1'b1;
          if (held_count >= limit) begin
            if (overflow_count != jcs_pkg::OVF_MAX) begin
              overflow_count_next = overflow_count + 1'b1;
            end
          end else begin
            held_count_next = held_count + 1'b1;
          end
        end
        jcs_pkg::OP_TICK: begin
          if (held_count == '0) begin
            tick_valid = last_valid;
          end else begin
            tick_valid      = 1'b1;
            last_valid_next = 1'b1;
            if (!smoothing_on || !last_valid) begin
              ctl.copy_target = 1'b1;
            end else begin
              ctl.blend = 1'b1;
            end
          end
        end
        jcs_pkg::OP_CLEAR: begin
          held_count_next = '0;
          last_valid_next = 1'b0;
        end
        jcs_pkg::OP_INIT: begin
          ctl.load_last   = 1'b1;
          held_count_next = '0;
          last_valid_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count     <= '0;
      overflow_count <= '0;
      last_valid     <= 1'b0;
    end else begin
      held_count     <= held_count_next;
      overflow_count <= overflow_count_next;
      last_valid     <= last_valid_next;
    end
  end

  assign occupancy      = held_count_next;
  assign overflow_total = overflow_count_next;

endmodule

// ===== design/jcs_merge.sv =====
// ---------------------------------------------------------------------------
// Result merge and output buffer
// Gathers the lane outputs and counters into one word and holds up to two.
// ---------------------------------------------------------------------------
module jcs_merge (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          push,
  input  logic                                          tick_valid,
  input  logic [jcs_pkg::JOINTS-1:0][jcs_pkg::POS_W-1:0] lane_pos,
  input  logic [jcs_pkg::COUNT_W-1:0]                   occupancy,
  input  logic [jcs_pkg::OVF_W-1:0]                     overflow_total,
  output logic                                          full,
  jcs_res_if.source                                     res
);

  jcs_pkg::res_t  wr_word;
  jcs_pkg::res_t  rd_word;
  jcs_pkg::res_t  buf_mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           pop;

  always_comb begin
    wr_word.out_valid      = tick_valid;
    wr_word.joints         = tick_valid ? lane_pos : '0;
    wr_word.occupancy      = occupancy;
    wr_word.overflow_total = overflow_total;
  end

  assign full = (count == 2'd2);
  assign pop  = res.valid && res.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign rd_word            = buf_mem[rd_ptr];
  assign res.valid          = (count != 2'd0);
  assign res.out_valid      = rd_word.out_valid;
  assign res.out_joint_a    = rd_word.joints[0];
  assign res.out_joint_b    = rd_word.joints[1];
  assign res.out_joint_c    = rd_word.joints[2];
  assign res.out_joint_d    = rd_word.joints[3];
  assign res.out_joint_e    = rd_word.joints[4];
  assign res.out_joint_f    = rd_word.joints[5];
  assign res.out_joint_g    = rd_word.joints[6];
  assign res.occupancy      = rd_word.occupancy;
  assign res.overflow_total = rd_word.overflow_total;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output buffer count out of range");

  a_push_only: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("output buffer did not grow on a push");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 2'd1))
    else $error("output buffer did not shrink on a pop");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'd2))
    else $error("word pushed into a full output buffer");

  a_quiet_zero: assert property (@(posedge clk) disable iff (rst)
    (push && !tick_valid) |-> (wr_word.joints == '0))
    else $error("non-tick word carries joint positions");
`endif

endmodule

// ===== design/joint_command_smoother_unit.sv =====
// ---------------------------------------------------------------------------
// Joint command smoother
// Seven-lane exponential smoother for servo joint commands.
// ---------------------------------------------------------------------------
// Words arrive on cmd (valid/ready): an operation code and seven Q15.16
// positions. Every accepted word yields exactly one word on res, carrying the
// tick output flag, seven positions and the occupancy and overflow counters.
// Seven lanes, one per joint, each hold the latest target and last output and
// perform the blend last + w*(target - last) with one 33x18 multiply; the
// lane's single feedback register sets the rate at one word per cycle while
// cmd is ready. Each result is written to the output buffer when its
// command is accepted. Results sit in a two-word output buffer, so cmd
// stays ready while one result waits; cmd.ready falls only when both entries
// are held, and nothing is lost while res is stalled.
// Reset (rst, synchronous) empties the buffer, zeroes occupancy and overflow,
// forgets the last output and restores the registers to smoothing on, weight
// one half and limit ten. The APB port writes the registers at byte addresses
// 0, 4 and 8; they should be written only while the block is idle.
// ---------------------------------------------------------------------------
module joint_command_smoother_unit (
  input  logic                          clk,
  input  logic                          rst,
  jcs_cmd_if.sink                       cmd,
  jcs_res_if.source                     res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jcs_pkg::ADDR_W-1:0]    paddr,
  input  logic [jcs_pkg::DATA_W-1:0]    pwdata,
  output logic [jcs_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic                                           smoothing_on;
  logic [jcs_pkg::WEIGHT_W-1:0]                   blend_weight;
  logic [jcs_pkg::COUNT_W-1:0]                    buffer_limit;
  logic [jcs_pkg::WEIGHT_W-1:0]                   weight;
  logic                                           accept;
  logic                                           full;
  logic                                           cfg_write;
  jcs_pkg::reg_idx_t                              reg_idx;
  jcs_pkg::lane_ctl_t                             ctl;
  logic                                           tick_valid;
  logic [jcs_pkg::COUNT_W-1:0]                    occupancy;
  logic [jcs_pkg::OVF_W-1:0]                      overflow_total;
  logic [jcs_pkg::JOINTS-1:0][jcs_pkg::POS_W-1:0] lane_in;
  logic [jcs_pkg::JOINTS-1:0][jcs_pkg::POS_W-1:0] lane_pos;

  assign pready    = 1'b1;
  assign reg_idx   = jcs_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_on <= 1'b1;
      blend_weight <= jcs_pkg::WEIGHT_RESET;
      buffer_limit <= jcs_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        jcs_pkg::REG_SMOOTHING_ON: smoothing_on <= pwdata[0];
        jcs_pkg::REG_BLEND_WEIGHT: blend_weight <= pwdata[jcs_pkg::WEIGHT_W-1:0];
        jcs_pkg::REG_BUFFER_LIMIT: buffer_limit <= pwdata[jcs_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      jcs_pkg::REG_SMOOTHING_ON: prdata = jcs_pkg::DATA_W'(smoothing_on);
      jcs_pkg::REG_BLEND_WEIGHT: prdata = jcs_pkg::DATA_W'(blend_weight);
      jcs_pkg::REG_BUFFER_LIMIT: prdata = jcs_pkg::DATA_W'(buffer_limit);
      default:                   prdata = '0;
    endcase
  end

  // Weights above one behave as exactly one.
  assign weight = (blend_weight > jcs_pkg::WEIGHT_ONE) ? jcs_pkg::WEIGHT_ONE
                                                       : blend_weight;

  assign cmd.ready = !full;
  assign accept    = cmd.valid && cmd.ready;

  assign lane_in[0] = cmd.joint_a;
  assign lane_in[1] = cmd.joint_b;
  assign lane_in[2] = cmd.joint_c;
  assign lane_in[3] = cmd.joint_d;
  assign lane_in[4] = cmd.joint_e;
  assign lane_in[5] = cmd.joint_f;
  assign lane_in[6] = cmd.joint_g;

  jcs_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .operation      (cmd.operation),
    .smoothing_on   (smoothing_on),
    .buffer_limit   (buffer_limit),
    .ctl            (ctl),
    .tick_valid     (tick_valid),
    .occupancy      (occupancy),
    .overflow_total (overflow_total)
  );

  for (genvar j = 0; j < jcs_pkg::JOINTS; j++) begin : g_lane
    jcs_lane u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .weight  (weight),
      .pos_in  (lane_in[j]),
      .pos_out (lane_pos[j])
    );
  end

  jcs_merge u_merge (
    .clk            (clk),
    .rst            (rst),
    .push           (accept),
    .tick_valid     (tick_valid),
    .lane_pos       (lane_pos),
    .occupancy      (occupancy),
    .overflow_total (overflow_total),
    .full           (full),
    .res            (res)
  );

endmodule
